// ----- rtl/core/efw_pkg.sv -----
// shared types and constants for the exon flank window block
`default_nettype none
package efw_pkg;

	localparam int DEF_MAX_EXON_SLOTS = 256;
	localparam logic [9:0] FLANK_RESET = 10'd50;
	localparam int COORD_W = 31;
	localparam int LEN_W = 11;
	// wide enough for sums over 4096 exons of signed coordinate differences
	localparam int SUM_W = 48;
	localparam int LEN_MAX = 2047;

	typedef logic signed [SUM_W-1:0] sw_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_UNLOADED = 2'd1,
		ST_OUTSIDE  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_BRD,
		BK_BEV,
		BK_FRD,
		BK_FEV,
		BK_CHK,
		BK_LRD,
		BK_LEV,
		BK_LFIN,
		BK_DONE
	} bk_state_t;

	typedef struct packed {
		logic               is_load;
		logic               slot_ok;
		logic [7:0]         idx;
		logic [COORD_W-1:0] exon_begin;
		logic [COORD_W-1:0] exon_finish;
		logic               last;
		logic [COORD_W-1:0] pos;
	} cmd_t;

	typedef struct packed {
		logic [COORD_W-1:0] window_start;
		logic [COORD_W-1:0] window_end;
		logic [LEN_W-1:0]   window_length;
		status_t            status;
	} res_t;

	function automatic sw_t ext31(input logic [COORD_W-1:0] x);
		ext31 = sw_t'({{(SUM_W-COORD_W){1'b0}}, x});
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/efw_front.sv -----
// front end: takes words, classifies them and queues commands for the back end
`default_nettype none
module efw_front import efw_pkg::*; #(
	parameter int MAX_EXON_SLOTS = DEF_MAX_EXON_SLOTS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic               kind,
	input  wire logic [7:0]         exon_index,
	input  wire logic [COORD_W-1:0] exon_begin,
	input  wire logic [COORD_W-1:0] exon_finish,
	input  wire logic               last_exon,
	input  wire logic [COORD_W-1:0] snp_position,
	output logic                    cmd_valid,
	input  wire logic               cmd_pop,
	output cmd_t                    cmd
);

	cmd_t       ent_q [2];
	logic [1:0] cnt_q;
	logic       wp_q;
	logic       rp_q;
	logic       do_push;
	logic       do_pop;
	cmd_t       cmd_in;

	always_comb begin
		cmd_in.is_load     = !kind;
		cmd_in.slot_ok     = (32'(exon_index) < MAX_EXON_SLOTS);
		cmd_in.idx         = exon_index;
		cmd_in.exon_begin  = exon_begin;
		cmd_in.exon_finish = exon_finish;
		cmd_in.last        = last_exon;
		cmd_in.pos         = snp_position;
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = ent_q[rp_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (do_push) wp_q <= !wp_q;
			if (do_pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) ent_q[wp_q] <= cmd_in;
	end

endmodule
`default_nettype wire

// ----- rtl/core/efw_back.sv -----
// back end: exon tables, flank walks, exon scan and length sum
`default_nettype none
module efw_back import efw_pkg::*; #(
	parameter int MAX_EXON_SLOTS = DEF_MAX_EXON_SLOTS
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [9:0] flank_size,
	input  wire logic       cmd_valid,
	output logic            cmd_pop,
	input  wire cmd_t       cmd,
	output logic            res_push,
	input  wire logic       res_full,
	output res_t            res
);

	localparam int AW = (MAX_EXON_SLOTS > 1) ? $clog2(MAX_EXON_SLOTS) : 1;
	localparam int TW = $clog2(MAX_EXON_SLOTS + 1);
	localparam int CW = (TW > 9) ? TW : 9;

	logic [COORD_W-1:0] mem_s [MAX_EXON_SLOTS];
	logic [COORD_W-1:0] mem_e [MAX_EXON_SLOTS];
	logic [COORD_W-1:0] rd_s;
	logic [COORD_W-1:0] rd_e;
	logic               wr_en;

	bk_state_t state_q, state_d;
	logic [TW-1:0] total_q;
	logic [AW-1:0] i_q, i_d;
	logic [7:0]    idx_q, idx_d;
	logic          first_q, first_d;
	sw_t           pos_q, pos_d;
	sw_t           need_q, need_d;
	sw_t           avail_q, avail_d;
	sw_t           ws_q, ws_d;
	sw_t           we_q, we_d;
	sw_t           acc_q, acc_d;
	sw_t           term_q, term_d;
	logic          sdone_q, sdone_d;
	logic          edone_q, edone_d;
	status_t       status_q, status_d;
	logic [LEN_W-1:0] len_q, len_d;

	sw_t  lo, hi, edge_b, edge_f, avail_b, avail_f, sum;
	sw_t  op_a, op_b;
	logic at_last, s_lt, s_in, e_lt, e_in, s_hit, e_hit, miss;

	assign wr_en = (state_q == BK_IDLE) && cmd_valid && cmd.is_load && cmd.slot_ok;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_s[AW'(cmd.idx)] <= cmd.exon_begin;
			mem_e[AW'(cmd.idx)] <= cmd.exon_finish;
		end
		rd_s <= mem_s[i_d];
		rd_e <= mem_e[i_d];
	end

	always_comb begin
		lo      = ext31(rd_s);
		hi      = ext31(rd_e);
		edge_b  = first_q ? pos_q : hi;
		edge_f  = first_q ? pos_q : lo;
		avail_b = edge_b - lo;
		avail_f = hi - edge_f;
		at_last = (CW'(i_q) + CW'(1)) == CW'(total_q);
		s_lt    = ws_q < lo;
		s_in    = ws_q <= hi;
		e_lt    = we_q < lo;
		e_in    = we_q <= hi;
		s_hit   = !sdone_q && !s_lt && s_in;
		e_hit   = !edone_q && !e_lt && e_in;
		miss    = (!sdone_q && s_lt) || (!edone_q && e_lt);
		sum     = acc_q + term_q;
		// operands of the length term for the current exon
		priority if (s_hit && e_hit) begin
			op_a = we_q;
			op_b = ws_q;
		end else if (s_hit) begin
			op_a = hi;
			op_b = ws_q;
		end else if (e_hit) begin
			op_a = we_q;
			op_b = lo;
		end else if (sdone_q && !edone_q) begin
			op_a = hi;
			op_b = lo;
		end else begin
			op_a = '0;
			op_b = '0;
		end
	end

	always_comb begin
		state_d  = state_q;
		i_d      = i_q;
		idx_d    = idx_q;
		first_d  = first_q;
		pos_d    = pos_q;
		need_d   = need_q;
		avail_d  = avail_q;
		ws_d     = ws_q;
		we_d     = we_q;
		acc_d    = acc_q;
		term_d   = term_q;
		sdone_d  = sdone_q;
		edone_d  = edone_q;
		status_d = status_q;
		len_d    = len_q;
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					if (!cmd.is_load) begin
						idx_d   = cmd.idx;
						i_d     = AW'(cmd.idx);
						first_d = 1'b1;
						pos_d   = ext31(cmd.pos);
						need_d  = sw_t'(flank_size);
						avail_d = '0;
						if (CW'(cmd.idx) < CW'(total_q)) begin
							state_d = BK_BRD;
						end else begin
							status_d = ST_UNLOADED;
							ws_d     = '0;
							we_d     = '0;
							len_d    = '0;
							state_d  = BK_DONE;
						end
					end
				end
			end
			BK_BRD: begin
				need_d  = need_q - avail_q;
				state_d = BK_BEV;
			end
			BK_BEV: begin
				first_d = 1'b0;
				avail_d = avail_b;
				if (avail_b >= need_q || i_q == '0) begin
					ws_d    = (avail_b >= need_q) ? (edge_b - need_q) : lo;
					i_d     = AW'(idx_q);
					first_d = 1'b1;
					need_d  = sw_t'(flank_size);
					avail_d = '0;
					state_d = BK_FRD;
				end else begin
					i_d     = i_q - AW'(1);
					state_d = BK_BRD;
				end
			end
			BK_FRD: begin
				need_d  = need_q - avail_q;
				state_d = BK_FEV;
			end
			BK_FEV: begin
				first_d = 1'b0;
				avail_d = avail_f;
				if (avail_f >= need_q) begin
					we_d    = edge_f + need_q;
					state_d = BK_CHK;
				end else if (at_last) begin
					we_d    = hi;
					state_d = BK_CHK;
				end else begin
					i_d     = i_q + AW'(1);
					state_d = BK_FRD;
				end
			end
			BK_CHK: begin
				if (we_q < ws_q) begin
					status_d = ST_OUTSIDE;
					len_d    = '0;
					state_d  = BK_DONE;
				end else begin
					i_d     = '0;
					acc_d   = '0;
					term_d  = '0;
					sdone_d = 1'b0;
					edone_d = 1'b0;
					state_d = BK_LRD;
				end
			end
			BK_LRD: begin
				acc_d   = sum;
				term_d  = '0;
				state_d = BK_LEV;
			end
			BK_LEV: begin
				term_d  = op_a - op_b;
				sdone_d = sdone_q || s_hit;
				edone_d = edone_q || e_hit;
				if (miss) begin
					status_d = ST_OUTSIDE;
					len_d    = '0;
					state_d  = BK_DONE;
				end else if ((sdone_q || s_hit) && (edone_q || e_hit)) begin
					state_d = BK_LFIN;
				end else if (at_last) begin
					status_d = ST_OUTSIDE;
					len_d    = '0;
					state_d  = BK_DONE;
				end else begin
					i_d     = i_q + AW'(1);
					state_d = BK_LRD;
				end
			end
			BK_LFIN: begin
				status_d = ST_OK;
				if (sum < 0) len_d = '0;
				else if (sum > sw_t'(LEN_MAX)) len_d = LEN_W'(LEN_MAX);
				else len_d = sum[LEN_W-1:0];
				state_d = BK_DONE;
			end
			BK_DONE: begin
				if (!res_full) begin
					res_push = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			total_q <= '0;
		end else begin
			state_q <= state_d;
			if (wr_en && cmd.last) total_q <= TW'({1'b0, cmd.idx} + 9'd1);
		end
	end

	always_ff @(posedge clk) begin
		i_q      <= i_d;
		idx_q    <= idx_d;
		first_q  <= first_d;
		pos_q    <= pos_d;
		need_q   <= need_d;
		avail_q  <= avail_d;
		ws_q     <= ws_d;
		we_q     <= we_d;
		acc_q    <= acc_d;
		term_q   <= term_d;
		sdone_q  <= sdone_d;
		edone_q  <= edone_d;
		status_q <= status_d;
		len_q    <= len_d;
	end

	always_comb begin
		res.window_start  = ws_q[COORD_W-1:0];
		res.window_end    = we_q[COORD_W-1:0];
		res.window_length = len_q;
		res.status        = status_q;
	end

endmodule
`default_nettype wire

// ----- rtl/core/efw_resq.sv -----
// two-entry result queue between the back end and the result port
`default_nettype none
module efw_resq import efw_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic res_push,
	output logic      res_full,
	input  wire res_t res_in,
	output logic      empty,
	input  wire logic pop,
	output res_t      res_out
);

	res_t       ent_q [2];
	logic [1:0] cnt_q;
	logic       wp_q;
	logic       rp_q;
	logic       do_push;
	logic       do_pop;

	assign res_full = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign res_out  = ent_q[rp_q];
	assign do_push  = res_push && !res_full;
	assign do_pop   = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (do_push) wp_q <= !wp_q;
			if (do_pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) ent_q[wp_q] <= res_in;
	end

endmodule
`default_nettype wire

// ----- rtl/core/exon_flank_window.sv -----
// exon flank window: top level with the flank size register
// Input words enter through a queue port (push, full): kind 0 loads one exon
// into slot exon_index, kind 1 asks for the flank window around snp_position
// inside exon exon_index. Loads give no result word; every query gives one.
// Results leave through a queue port (empty, pop); the oldest result sits on
// the outputs while empty is low. A two-entry command queue and a two-entry
// result queue decouple the ports from the sequencer.
// A load is written into the exon tables as it leaves the command queue. In
// the sequencer a query walks backward and then forward from its exon, then
// scans the exons from the first one until both window ends are placed;
// every step costs one table read and one evaluation. A query for an exon
// not loaded goes straight to its result. Reset empties both queues, clears
// the exon count and sets flank_size to 50; table contents are undefined
// until loaded. When the consumer stops popping, the result queue fills, the
// sequencer waits, then the command queue fills and full rises. flank_size is
// written through cfg_we and cfg_wdata; the user must write it only while the
// block is idle, which the block itself does not enforce.
`default_nettype none
module exon_flank_window import efw_pkg::*; #(
	parameter int MAX_EXON_SLOTS = DEF_MAX_EXON_SLOTS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic               kind,
	input  wire logic [7:0]         exon_index,
	input  wire logic [COORD_W-1:0] exon_begin,
	input  wire logic [COORD_W-1:0] exon_finish,
	input  wire logic               last_exon,
	input  wire logic [COORD_W-1:0] snp_position,
	output logic                    empty,
	input  wire logic               pop,
	output logic [COORD_W-1:0]      window_start,
	output logic [COORD_W-1:0]      window_end,
	output logic [LEN_W-1:0]        window_length,
	output logic [1:0]              status,
	input  wire logic               cfg_we,
	input  wire logic [9:0]         cfg_wdata
);

	logic [9:0] flank_q;
	logic       cmd_valid;
	logic       cmd_pop;
	cmd_t       cmd;
	logic       res_push;
	logic       res_full;
	res_t       res_bk;
	res_t       res_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flank_q <= FLANK_RESET;
		end else if (cfg_we) begin
			flank_q <= cfg_wdata;
		end
	end

	efw_front #(.MAX_EXON_SLOTS(MAX_EXON_SLOTS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.kind        (kind),
		.exon_index  (exon_index),
		.exon_begin  (exon_begin),
		.exon_finish (exon_finish),
		.last_exon   (last_exon),
		.snp_position(snp_position),
		.cmd_valid   (cmd_valid),
		.cmd_pop     (cmd_pop),
		.cmd         (cmd)
	);

	efw_back #(.MAX_EXON_SLOTS(MAX_EXON_SLOTS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.flank_size(flank_q),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.res_push  (res_push),
		.res_full  (res_full),
		.res       (res_bk)
	);

	efw_resq u_resq (
		.clk     (clk),
		.arst_n  (arst_n),
		.res_push(res_push),
		.res_full(res_full),
		.res_in  (res_bk),
		.empty   (empty),
		.pop     (pop),
		.res_out (res_out)
	);

	assign window_start  = res_out.window_start;
	assign window_end    = res_out.window_end;
	assign window_length = res_out.window_length;
	assign status        = res_out.status;

endmodule
`default_nettype wire
